// ===== rtl/aumb_pkg.sv =====
// Shared types and constants of the adaptive unsharp-mask blend.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package aumb_pkg;

  // Amount format: signed, fixed width regardless of pixel width.
  localparam int AMOUNT_BITS = 24;
  // Fraction bits of the normalized brightness offset u.
  localparam int CURVE_FRAC  = 16;
  // Quotient bits of the u division (u magnitude reaches one).
  localparam int QUO_BITS    = CURVE_FRAC + 1;
  // Cubic term is rounded by this many bits before it weights the span.
  localparam int HR_SHIFT    = 24;
  // Weight = 2^WGT_ONE_SH + rounded cubic, blend shift of the span product.
  localparam int WGT_ONE_SH  = 25;
  localparam int SPAN_SHIFT  = 26;

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_RESET = 24'sd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADAPTIVE_MODE    = 3'd0,
    REG_AMOUNT_MIN       = 3'd1,
    REG_AMOUNT_MAX       = 3'd2,
    REG_BRIGHT_THRESHOLD = 3'd3,
    REG_TRANSITION_WIDTH = 3'd4
  } cfg_reg_t;

  // Position of the brightness relative to the transition band.
  typedef struct packed {
    logic neg;    // brightness below threshold
    logic below;  // below threshold minus width
    logic above;  // above threshold plus width
  } curve_flags_t;

  // Amount settings seen by the amount stages.
  typedef struct packed {
    logic                          adaptive;
    logic signed [AMOUNT_BITS-1:0] amt_min;
    logic signed [AMOUNT_BITS-1:0] amt_max;
  } amt_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/aumb_if.sv =====
// Channel interfaces of the blend: pixel input, result output, register writes.
// Depends on aumb_pkg for the configuration widths.
`default_nettype none
interface aumb_in_if #(parameter int PIXEL_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic [PIXEL_BITS-1:0] blurred_value;
  logic [PIXEL_BITS-1:0] brightness_value;
  modport source (output valid, pixel_value, blurred_value, brightness_value, input ready);
  modport sink   (input valid, pixel_value, blurred_value, brightness_value, output ready);
endinterface

interface aumb_out_if #(parameter int PIXEL_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] sharpened_value;
  modport source (output valid, sharpened_value, input ready);
  modport sink   (input valid, sharpened_value, output ready);
endinterface

interface aumb_cfg_if ();
  import aumb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aumb_div.sv =====
// Pipelined restoring divider for u = round(|t| * 2^16 / width), one bit per stage.
// Depends on aumb_pkg; sideband bits travel with each quotient.
`default_nettype none
module aumb_div #(
  parameter int PIXEL_BITS = 16,
  parameter int SIDE_W     = 35
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     adv,
  input  wire logic                                     in_vld,
  input  wire logic [PIXEL_BITS+aumb_pkg::QUO_BITS-1:0] num,
  input  wire logic [PIXEL_BITS-1:0]                    den,
  input  wire logic [SIDE_W-1:0]                        side,
  output logic                                          out_vld,
  output logic [aumb_pkg::QUO_BITS-1:0]                 quo,
  output logic [SIDE_W-1:0]                             side_o
);
  import aumb_pkg::*;

  localparam int NUM_W = PIXEL_BITS + QUO_BITS;

  logic [PIXEL_BITS-1:0] rem_r  [QUO_BITS];
  logic [QUO_BITS-1:0]   low_r  [QUO_BITS];
  logic [QUO_BITS-1:0]   quo_r  [QUO_BITS];
  logic [SIDE_W-1:0]     side_r [QUO_BITS];
  logic [QUO_BITS-1:0]   vld_r;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [PIXEL_BITS-1:0] rem_i;
    logic [QUO_BITS-1:0]   low_i;
    logic [QUO_BITS-1:0]   quo_i;
    logic [SIDE_W-1:0]     side_i;
    logic                  vld_i;
    logic [PIXEL_BITS:0]   trial;
    logic                  fits;

    // The top bits of the numerator start as remainder; they stay below width while the brightness is inside the band.
    if (k == 0) begin : g_first
      assign rem_i  = num[NUM_W-1:QUO_BITS];
      assign low_i  = num[QUO_BITS-1:0];
      assign quo_i  = '0;
      assign side_i = side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign low_i  = low_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    // Bring down one numerator bit and subtract the width where it fits.
    assign trial = {rem_i, low_i[QUO_BITS-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= fits ? PIXEL_BITS'(trial - {1'b0, den}) : trial[PIXEL_BITS-1:0];
        low_r[k]  <= {low_i[QUO_BITS-2:0], 1'b0};
        quo_r[k]  <= {quo_i[QUO_BITS-2:0], fits};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld = vld_r[QUO_BITS-1];
  assign quo     = quo_r[QUO_BITS-1];
  assign side_o  = side_r[QUO_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/aumb_amt.sv =====
// Amount stages: cubic of u, span weighting and the selection of the amount.
// Depends on aumb_pkg; five register stages fed by the divider.
`default_nettype none
module aumb_amt #(
  parameter int SIDE_W = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 adv,
  input  wire logic                                 in_vld,
  input  wire logic [aumb_pkg::QUO_BITS-1:0]        quo,
  input  wire aumb_pkg::curve_flags_t               flags,
  input  wire aumb_pkg::amt_cfg_t                   cfg,
  input  wire logic [SIDE_W-1:0]                    side,
  output logic                                      out_vld,
  output logic signed [aumb_pkg::AMOUNT_BITS-1:0]   amount,
  output logic [SIDE_W-1:0]                         side_o
);
  import aumb_pkg::*;

  localparam int Q2_W   = 2 * QUO_BITS;
  localparam int Q3_W   = 3 * QUO_BITS;
  localparam int H_W    = Q3_W + 1;
  localparam int HR_W   = H_W - HR_SHIFT;
  localparam int WGT_W  = WGT_ONE_SH + 2;
  localparam int DIFF_W = AMOUNT_BITS + 1;
  localparam int PROD_W = DIFF_W + WGT_W + 1;

  logic [4:0]            vld_r;
  curve_flags_t          fl_r [4];
  logic [SIDE_W-1:0]     sd_r [5];
  logic [QUO_BITS-1:0]   m1_r, m2_r;
  logic [Q2_W-1:0]       q2_r;
  logic [Q3_W-1:0]       q3_r;
  logic [WGT_W-1:0]      wgt_r, wgt_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [AMOUNT_BITS-1:0] amt_r, amt_nxt;

  // Cubic term h = 3*m*2^32 - m^3 in magnitude, signed by the offset, rounded.
  logic [QUO_BITS:0]       m3;
  logic [Q3_W-1:0]         hmag;
  logic signed [H_W-1:0]   h, hrnd;
  logic signed [HR_W-1:0]  hr;
  always_comb begin
    m3      = {m2_r, 1'b0} + {1'b0, m2_r};
    hmag    = Q3_W'({m3, {(2 * CURVE_FRAC){1'b0}}}) - q3_r;
    h       = fl_r[1].neg ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
    hrnd    = h + $signed(H_W'(1) << (HR_SHIFT - 1));
    hr      = HR_W'(hrnd >>> HR_SHIFT);
    wgt_nxt = WGT_W'(hr) + (WGT_W'(1) << WGT_ONE_SH);
  end

  // Span times weight.
  logic signed [DIFF_W-1:0] diff;
  always_comb begin
    diff     = $signed({cfg.amt_max[AMOUNT_BITS-1], cfg.amt_max})
             - $signed({cfg.amt_min[AMOUNT_BITS-1], cfg.amt_min});
    prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, wgt_r}));
  end

  // Round the weighted span onto the dark-region amount, then choose by band and mode.
  logic signed [PROD_W-1:0] prnd, pshift;
  always_comb begin
    prnd   = prod_r + $signed(PROD_W'(1) << (SPAN_SHIFT - 1));
    pshift = prnd >>> SPAN_SHIFT;
    if (!cfg.adaptive || fl_r[3].above) begin
      amt_nxt = cfg.amt_max;
    end else if (fl_r[3].below) begin
      amt_nxt = cfg.amt_min;
    end else begin
      amt_nxt = AMOUNT_BITS'(pshift) + cfg.amt_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= quo;
      q2_r   <= Q2_W'(quo) * Q2_W'(quo);
      m2_r   <= m1_r;
      q3_r   <= Q3_W'(q2_r) * Q3_W'(m1_r);
      wgt_r  <= wgt_nxt;
      prod_r <= prod_nxt;
      amt_r  <= amt_nxt;
      fl_r[0] <= flags;
      fl_r[1] <= fl_r[0];
      fl_r[2] <= fl_r[1];
      fl_r[3] <= fl_r[2];
      sd_r[0] <= side;
      sd_r[1] <= sd_r[0];
      sd_r[2] <= sd_r[1];
      sd_r[3] <= sd_r[2];
      sd_r[4] <= sd_r[3];
    end
  end

  assign out_vld = vld_r[4];
  assign amount  = amt_r;
  assign side_o  = sd_r[4];

endmodule
`default_nettype wire

// ===== rtl/aumb_blend.sv =====
// Blend stages: blur + amount*(pixel - blur), rounding, saturation, output register.
// Depends on aumb_pkg for the amount width.
`default_nettype none
module aumb_blend #(
  parameter int PIXEL_BITS       = 16,
  parameter int AMOUNT_FRAC_BITS = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    adv,
  input  wire logic                                    in_vld,
  input  wire logic signed [aumb_pkg::AMOUNT_BITS-1:0] amount,
  input  wire logic [PIXEL_BITS-1:0]                   pix,
  input  wire logic [PIXEL_BITS-1:0]                   blur,
  output logic                                         out_vld,
  output logic [PIXEL_BITS-1:0]                        result
);
  import aumb_pkg::*;

  localparam int ACC_W = AMOUNT_BITS + PIXEL_BITS + 2;

  logic                      acc_vld_r, res_vld_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [PIXEL_BITS-1:0]     res_r, res_nxt;

  // Multiply-accumulate of the detail term.
  logic signed [PIXEL_BITS:0] detail;
  always_comb begin
    detail  = $signed({1'b0, pix}) - $signed({1'b0, blur});
    acc_nxt = ACC_W'(amount) * ACC_W'(detail)
            + ACC_W'($signed({1'b0, blur, {AMOUNT_FRAC_BITS{1'b0}}}));
  end

  // Round half up and saturate to the pixel range.
  logic signed [ACC_W-1:0] arnd, ashift;
  always_comb begin
    arnd   = acc_r + $signed(ACC_W'(1) << (AMOUNT_FRAC_BITS - 1));
    ashift = arnd >>> AMOUNT_FRAC_BITS;
    if (ashift < 0) begin
      res_nxt = '0;
    end else if (ashift > $signed({1'b0, {PIXEL_BITS{1'b1}}})) begin
      res_nxt = '1;
    end else begin
      res_nxt = ashift[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else if (adv) begin
      acc_vld_r <= in_vld;
      res_vld_r <= acc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld = res_vld_r;
  assign result  = res_r;

endmodule
`default_nettype wire

// ===== rtl/adaptive_unsharp_mask_blend.sv =====
// Top level of the adaptive unsharp-mask blend: registers, front stage and pipeline.
// Depends on aumb_pkg, aumb_if, aumb_div, aumb_amt and aumb_blend.
//
//   Channel  Direction  Carries
//   in_ch    sink       pixel_value, blurred_value, brightness_value
//   out_ch   source     sharpened_value
//   cfg_ch   sink       index, data (register write, always ready)
//
// One pixel per clock is taken while out_ch does not stall; the stages are the front stage, 17 divider
// stages (one per quotient bit), 5 amount stages and 2 blend stages.
// Reset clears the valid bits and loads the register reset values.
// A stall on out_ch freezes all stages together; in_ch.ready follows it.
`default_nettype none
module adaptive_unsharp_mask_blend #(
  parameter int PIXEL_BITS       = 16,
  parameter int AMOUNT_FRAC_BITS = 12
) (
  input wire logic  clk,
  input wire logic  rst_n,
  aumb_in_if.sink   in_ch,
  aumb_out_if.source out_ch,
  aumb_cfg_if.sink  cfg_ch
);
  import aumb_pkg::*;

  localparam int NUM_W  = PIXEL_BITS + QUO_BITS;
  localparam int PS_W   = 2 * PIXEL_BITS;
  localparam int SIDE_W = PS_W + $bits(curve_flags_t);
  localparam logic [PIXEL_BITS-1:0] THR_RESET = PIXEL_BITS'(32'd32768);
  localparam logic [PIXEL_BITS-1:0] WID_RESET = PIXEL_BITS'(32'd4096);

  // Configuration registers.
  logic                          mode_r;
  logic signed [AMOUNT_BITS-1:0] amin_r, amax_r;
  logic [PIXEL_BITS-1:0]         thr_r, wid_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      amin_r <= AMOUNT_RESET;
      amax_r <= AMOUNT_RESET;
      thr_r  <= THR_RESET;
      wid_r  <= WID_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ADAPTIVE_MODE:    mode_r <= cfg_ch.data[0];
        REG_AMOUNT_MIN:       amin_r <= $signed(cfg_ch.data[AMOUNT_BITS-1:0]);
        REG_AMOUNT_MAX:       amax_r <= $signed(cfg_ch.data[AMOUNT_BITS-1:0]);
        REG_BRIGHT_THRESHOLD: thr_r  <= cfg_ch.data[PIXEL_BITS-1:0];
        REG_TRANSITION_WIDTH: wid_r  <= cfg_ch.data[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero width behaves as a width of one.
  logic [PIXEL_BITS-1:0] w_eff;
  assign w_eff = (wid_r == '0) ? PIXEL_BITS'(1) : wid_r;

  // The whole pipeline moves when the output register is free or drained.
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Front stage: brightness offset, band flags and the divider numerator.
  logic signed [PIXEL_BITS:0] t;
  logic [PIXEL_BITS-1:0]      mag;
  curve_flags_t               fl_nxt, f_fl_r;
  logic [NUM_W-1:0]           num_nxt, f_num_r;
  logic [PIXEL_BITS-1:0]      f_pix_r, f_blur_r;
  logic                       f_vld_r;

  always_comb begin
    t            = $signed({1'b0, in_ch.brightness_value}) - $signed({1'b0, thr_r});
    fl_nxt.neg   = t[PIXEL_BITS];
    mag          = fl_nxt.neg ? PIXEL_BITS'(-t) : t[PIXEL_BITS-1:0];
    fl_nxt.below = fl_nxt.neg && (mag > w_eff);
    fl_nxt.above = !fl_nxt.neg && (mag > w_eff);
    num_nxt      = NUM_W'({mag, {CURVE_FRAC{1'b0}}}) + NUM_W'(w_eff >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_fl_r   <= fl_nxt;
      f_num_r  <= num_nxt;
      f_pix_r  <= in_ch.pixel_value;
      f_blur_r <= in_ch.blurred_value;
    end
  end

  // Divider.
  logic                  d_vld;
  logic [QUO_BITS-1:0]   d_quo;
  logic [SIDE_W-1:0]     d_side;
  curve_flags_t          d_fl;

  aumb_div #(
    .PIXEL_BITS (PIXEL_BITS),
    .SIDE_W     (SIDE_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (f_vld_r),
    .num     (f_num_r),
    .den     (w_eff),
    .side    ({f_fl_r, f_pix_r, f_blur_r}),
    .out_vld (d_vld),
    .quo     (d_quo),
    .side_o  (d_side)
  );

  assign d_fl = d_side[SIDE_W-1:PS_W];

  // Amount.
  amt_cfg_t                      acfg;
  logic                          a_vld;
  logic signed [AMOUNT_BITS-1:0] a_amt;
  logic [PS_W-1:0]               a_side;

  assign acfg.adaptive = mode_r;
  assign acfg.amt_min  = amin_r;
  assign acfg.amt_max  = amax_r;

  aumb_amt #(
    .SIDE_W (PS_W)
  ) u_amt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (d_vld),
    .quo     (d_quo),
    .flags   (d_fl),
    .cfg     (acfg),
    .side    (d_side[PS_W-1:0]),
    .out_vld (a_vld),
    .amount  (a_amt),
    .side_o  (a_side)
  );

  // Blend and output register.
  aumb_blend #(
    .PIXEL_BITS       (PIXEL_BITS),
    .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
  ) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (a_vld),
    .amount  (a_amt),
    .pix     (a_side[PS_W-1:PIXEL_BITS]),
    .blur    (a_side[PIXEL_BITS-1:0]),
    .out_vld (out_ch.valid),
    .result  (out_ch.sharpened_value)
  );

  // The divisor is never zero.
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n) w_eff != '0)
    else $error("effective transition width is zero");

  // A brightness cannot lie on both sides of the band.
  a_band_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_fl_r.below && f_fl_r.above))
    else $error("band flags both set");

  // While the output stalls, the front stage holds its item.
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(f_vld_r) && $stable(f_num_r)))
    else $error("front stage changed during a stall");

endmodule
`default_nettype wire

// ===== tb/aumb_tb_ifs.sv =====
`timescale 1ns / 1ps
// Testbench-side channel interfaces are those of the block (aumb_if.sv).
// This file holds a small package of testbench types; depends on aumb_pkg.
package aumb_tb_pkg;
  import aumb_pkg::*;

  // One pixel transfer on the input channel.
  typedef struct packed {
    logic [15:0] pixel_value;
    logic [15:0] blurred_value;
    logic [15:0] brightness_value;
  } pixel_item_t;
endpackage

// ===== tb/adaptive_unsharp_mask_blend_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of adaptive_unsharp_mask_blend: random and directed pixels,
// register settings, stalls on both sides. Depends on aumb_pkg, aumb_if, aumb_tb_pkg.
module adaptive_unsharp_mask_blend_tb;
  import aumb_pkg::*;
  import aumb_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aumb_in_if  #(.PIXEL_BITS(16)) in_ch ();
  aumb_out_if #(.PIXEL_BITS(16)) out_ch ();
  aumb_cfg_if cfg_ch ();

  adaptive_unsharp_mask_blend dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the register file.
  logic                    mode_q;
  logic signed [23:0]      amt_min_q;
  logic signed [23:0]      amt_max_q;
  logic [15:0]             thresh_q;
  logic [15:0]             width_q;

  logic [15:0] sharpened_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  bit long_gaps = 1'b1;

  // Round half up by k bits (arithmetic shift is floor).
  function automatic longint round_shr(longint x, int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  // Amount selected by brightness under the current settings.
  function automatic longint sharpen_amount(logic [15:0] lum);
    longint w, t, mag, q, h, hr, wgt;
    if (!mode_q) return longint'(amt_max_q);
    w = (width_q == 0) ? 1 : width_q;
    t = longint'(lum) - longint'(thresh_q);
    if (t < -w) return longint'(amt_min_q);
    if (t > w) return longint'(amt_max_q);
    mag = (t < 0) ? -t : t;
    q = ((mag << 16) + w / 2) / w;
    if (t < 0) q = -q;
    h = 3 * q * (longint'(1) << 32) - q * q * q;
    hr = round_shr(h, 24);
    wgt = (longint'(1) << 25) + hr;
    return longint'(amt_min_q) +
           round_shr((longint'(amt_max_q) - longint'(amt_min_q)) * wgt, 26);
  endfunction

  // Blended and saturated pixel for one input transfer.
  function automatic logic [15:0] blend_pixel(pixel_item_t it);
    longint amt, acc, r;
    amt = sharpen_amount(it.brightness_value);
    acc = longint'(it.blurred_value) * 4096 +
          amt * (longint'(it.pixel_value) - longint'(it.blurred_value));
    r = round_shr(acc, 12);
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  function automatic int gap_len();
    if (!long_gaps) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one pixel; the expectation is queued at the transfer.
  // Valid stays high after a transfer so that the next one can follow with no gap.
  task automatic send_pixel(pixel_item_t it);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_value <= it.pixel_value;
    in_ch.blurred_value <= it.blurred_value;
    in_ch.brightness_value <= it.brightness_value;
    do @(posedge clk); while (!in_ch.ready);
    sharpened_queue.push_back(blend_pixel(it));
    n_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ADAPTIVE_MODE:    mode_q <= val[0];
      REG_AMOUNT_MIN:       amt_min_q <= val;
      REG_AMOUNT_MAX:       amt_max_q <= val;
      REG_BRIGHT_THRESHOLD: thresh_q <= val[15:0];
      REG_TRANSITION_WIDTH: width_q <= val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering pixels, wait until all results are in, then let the pipeline drain.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sharpened_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_all(logic mode, logic [23:0] amin, logic [23:0] amax,
                         logic [15:0] th, logic [15:0] wd);
    wait_drained();
    write_reg(REG_ADAPTIVE_MODE, {23'd0, mode});
    write_reg(REG_AMOUNT_MIN, amin);
    write_reg(REG_AMOUNT_MAX, amax);
    write_reg(REG_BRIGHT_THRESHOLD, {8'd0, th});
    write_reg(REG_TRANSITION_WIDTH, {8'd0, wd});
  endtask

  function automatic pixel_item_t rand_item();
    pixel_item_t it;
    it.pixel_value = 16'($urandom);
    it.blurred_value = 16'($urandom);
    it.brightness_value = 16'($urandom);
    return it;
  endfunction

  // Pixels around the threshold and band edges.
  function automatic pixel_item_t band_item();
    pixel_item_t it;
    longint l;
    it = rand_item();
    l = longint'(thresh_q) + $signed($urandom_range(0, 2 * 4 + 2)) - 5;
    case ($urandom_range(0, 3))
      0: l = longint'(thresh_q) - width_q + $signed($urandom_range(0, 4)) - 2;
      1: l = longint'(thresh_q) + width_q + $signed($urandom_range(0, 4)) - 2;
      2: l = longint'(thresh_q) + $signed($urandom_range(0, 2 * width_q)) - width_q;
      default: ;
    endcase
    if (l < 0) l = 0;
    if (l > 65535) l = 65535;
    it.brightness_value = l[15:0];
    return it;
  endfunction

  // Directed extremes under reset settings and non-adaptive mode.
  task automatic test_extremes();
    pixel_item_t it;
    it = '{16'hFFFF, 16'h0000, 16'h0000}; send_pixel(it);
    it = '{16'h0000, 16'hFFFF, 16'hFFFF}; send_pixel(it);
    it = '{16'hFFFF, 16'hFFFF, 16'h8000}; send_pixel(it);
    it = '{16'h0000, 16'h0000, 16'h0000}; send_pixel(it);
    it = '{16'h1234, 16'h5678, 16'h9ABC}; send_pixel(it);
    // Large amounts drive the result to both saturation limits.
    set_all(1'b0, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h1000);
    it = '{16'hFFFF, 16'h0000, 16'h0000}; send_pixel(it);
    it = '{16'h0000, 16'hFFFF, 16'h0000}; send_pixel(it);
    set_all(1'b0, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h1000);
    it = '{16'hFFFF, 16'h0000, 16'h0000}; send_pixel(it);
    it = '{16'h0000, 16'hFFFF, 16'h0000}; send_pixel(it);
    it = '{16'h8001, 16'h8000, 16'h0000}; send_pixel(it);
  endtask

  // Directed band edges, threshold and zero width in adaptive mode.
  task automatic test_band_edges();
    pixel_item_t it;
    set_all(1'b1, 24'hFFF000, 24'h003000, 16'h8000, 16'h1000);
    it = '{16'hC000, 16'h4000, 16'h7000}; send_pixel(it);
    it = '{16'hC000, 16'h4000, 16'h6FFF}; send_pixel(it);
    it = '{16'hC000, 16'h4000, 16'h9000}; send_pixel(it);
    it = '{16'hC000, 16'h4000, 16'h9001}; send_pixel(it);
    it = '{16'hC000, 16'h4000, 16'h8000}; send_pixel(it);
    it = '{16'hC000, 16'h4000, 16'h7801}; send_pixel(it);
    // A zero width behaves as a width of one.
    set_all(1'b1, 24'h000000, 24'h002000, 16'h8000, 16'h0000);
    it = '{16'hF000, 16'h1000, 16'h7FFF}; send_pixel(it);
    it = '{16'hF000, 16'h1000, 16'h8000}; send_pixel(it);
    it = '{16'hF000, 16'h1000, 16'h8001}; send_pixel(it);
    it = '{16'hF000, 16'h1000, 16'h7FFE}; send_pixel(it);
    // Extreme threshold and widest band.
    set_all(1'b1, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    it = '{16'hFFFF, 16'h0000, 16'h0000}; send_pixel(it);
    it = '{16'h0000, 16'hFFFF, 16'hFFFF}; send_pixel(it);
  endtask

  // Random pixels under several random and extreme settings.
  task automatic test_random();
    int k, j;
    for (k = 0; k < 8; k++) begin
      case (k)
        0: set_all(1'b1, 24'h001000, 24'h004000, 16'h8000, 16'h2000);
        1: set_all(1'b1, 24'h7FFFFF, 24'h800000, 16'h0000, 16'h0001);
        2: set_all(1'b0, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
        default: set_all(1'b1, {{6{1'b0}}, 18'($urandom)} - 24'h010000,
                         24'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
      endcase
      for (j = 0; j < 50; j++) send_pixel(($urandom_range(0, 3) == 0) ? rand_item()
                                                                     : band_item());
    end
  endtask

  // Receiver holds off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    int j;
    long_gaps = 1'b0;
    hold_receiver = 1'b1;
    for (j = 0; j < 40; j++) send_pixel(band_item());
    long_gaps = 1'b1;
  endtask

  // Result side: stalls of random length and a long hold-off on request.
  initial begin
    int g, hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 100; hold++) @(posedge clk);
        hold_receiver = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sharpened_queue.size() == 0) begin
        $display("unexpected result %0d at %0t", out_ch.sharpened_value, $realtime);
        errors++;
      end else begin
        if (out_ch.sharpened_value !== sharpened_queue[0])
          report_mismatch("sharpened_value", out_ch.sharpened_value, sharpened_queue[0]);
        void'(sharpened_queue.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || cfg_ch.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", sharpened_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.pixel_value <= '0;
    in_ch.blurred_value <= '0;
    in_ch.brightness_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ADAPTIVE_MODE;
    cfg_ch.data <= '0;
    mode_q = 1'b0;
    amt_min_q = AMOUNT_RESET;
    amt_max_q = AMOUNT_RESET;
    thresh_q = 16'd32768;
    width_q = 16'd4096;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_band_edges();
    test_backpressure();
    test_random();
    wait_drained();
    $display("Sent %0d pixels and checked %0d results over extreme and random settings,",
             n_sent, n_checked);
    $display("including band edges, zero width, saturation and output back-pressure.");
    if (errors == 0 && sharpened_queue.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/aumb_pkg.sv
rtl/aumb_if.sv
rtl/aumb_div.sv
rtl/aumb_amt.sv
rtl/aumb_blend.sv
rtl/adaptive_unsharp_mask_blend.sv
tb/aumb_tb_ifs.sv
tb/adaptive_unsharp_mask_blend_tb.sv
